[design/rcpg_pkg.sv]
// Package for the random cyclic permutation generator.
// Holds actions, register indexes, widths, reset values, xorshift constants and step; no dependencies.
package rcpg_pkg;
    localparam int unsigned LcW = 13;
    localparam int unsigned IdxW = 12;
    localparam int unsigned CfgW = 64;
    localparam int unsigned CfgAddrW = 1;
    localparam int unsigned MaxLines = 4096;
    localparam logic [63:0] SeedReset = 64'h9e3779b97f4a7c15;
    localparam logic [LcW-1:0] LineCountReset = 13'd4096;
    localparam int unsigned XsA = 13;
    localparam int unsigned XsB = 7;
    localparam int unsigned XsC = 17;

    typedef enum logic [0:0] {
        ACT_GENERATE = 1'b0,
        ACT_QUERY    = 1'b1
    } action_t;

    typedef enum logic [CfgAddrW-1:0] {
        REG_LINE_COUNT = 1'b0,
        REG_SEED       = 1'b1
    } reg_index_t;

    function automatic logic [63:0] xorshift_step(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << XsA);
        b = a ^ (a >> XsB);
        return b ^ (b << XsC);
    endfunction
endpackage

[design/random_cyclic_permutation_gen_unit.sv]
// Random cyclic permutation generator: Fisher-Yates shuffle driven by xorshift64.
// Sequence: a query reads its entry in S_Q_READ and registers the result in S_Q_OUT, then
// gives its result beat; a generate holds busy through fill, then per swap a draw, the
// bit-serial remainder unit and the swap writes, then link and finish, then its result beat.
// One item at a time: the next start is taken in the result cycle. Results cannot stall.
// Reset (async, active low) restores register defaults and marks tables invalid.
module random_cyclic_permutation_gen_unit
    import rcpg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [IdxW-1:0]              index,
    input  logic                         cfg_we,
    input  logic [CfgAddrW-1:0]          cfg_index,
    input  logic [CfgW-1:0]              cfg_data,
    output logic                         done,
    output logic [IdxW-1:0]              line_at_position,
    output logic [IdxW-1:0]              successor_line,
    output logic                         table_valid,
    output logic                         out_of_range
);
    localparam int unsigned AW = $clog2(MaxLines);
    localparam int unsigned NW = AW + 1;
    localparam logic [NW-1:0] MaxN = NW'(MaxLines);

    typedef enum logic [3:0] {
        S_IDLE, S_Q_READ, S_Q_OUT, S_FILL, S_RAND, S_DIV, S_RD_I, S_RD_J, S_SWAP,
        S_L_RD0, S_L_RD, S_L_WR, S_DONE
    } state_t;

    state_t          state_reg;
    logic [LcW-1:0]  line_count_reg;
    logic [63:0]     seed_reg;
    logic [63:0]     gen_reg;
    logic            ready_reg;
    logic [NW-1:0]   n_reg;
    logic [AW-1:0]   i_reg;
    logic [AW-1:0]   j_reg;
    logic [AW-1:0]   vi_reg;
    logic [AW-1:0]   first_reg;
    logic [AW-1:0]   cur_reg;
    logic            oor_reg;
    logic [IdxW-1:0] qidx_reg;
    logic            swap_hi_reg;

    logic [NW-1:0]   n_eff;
    logic [63:0]     rand_next;
    logic            div_go;
    logic            div_done;
    logic [NW-1:0]   div_rem;
    logic            ord_we;
    logic [AW-1:0]   ord_waddr;
    logic [AW-1:0]   ord_wdata;
    logic [AW-1:0]   ord_raddr;
    logic [AW-1:0]   ord_rdata;
    logic            suc_we;
    logic [AW-1:0]   suc_waddr;
    logic [AW-1:0]   suc_wdata;
    logic [AW-1:0]   suc_rdata;

    // clamp line count: zero acts as one, anything above capacity as capacity
    always_comb
    begin
        priority if (line_count_reg == '0)
            n_eff = NW'(1);
        else if (line_count_reg > LcW'(MaxLines))
            n_eff = MaxN;
        else
            n_eff = NW'(line_count_reg);
    end

    // next generator draw; the divider takes it at go, gen_reg takes it the same edge
    assign rand_next = xorshift_step(gen_reg);

    rcpg_divider #(.DW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (rand_next),
        .divisor  (NW'(i_reg) + NW'(1)),
        .done     (div_done),
        .remainder(div_rem)
    );

    rcpg_tables #(.AW(AW)) u_tab (
        .clk      (clk),
        .ord_we   (ord_we),
        .ord_waddr(ord_waddr),
        .ord_wdata(ord_wdata),
        .ord_raddr(ord_raddr),
        .ord_rdata(ord_rdata),
        .suc_we   (suc_we),
        .suc_waddr(suc_waddr),
        .suc_wdata(suc_wdata),
        .suc_raddr(qidx_reg[AW-1:0]),
        .suc_rdata(suc_rdata)
    );

    assign div_go = (state_reg == S_RAND);
    assign busy   = (state_reg != S_IDLE);

    // memory port steering per sequencer step
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = i_reg;
        ord_wdata = i_reg;
        ord_raddr = i_reg;
        suc_we    = 1'b0;
        suc_waddr = cur_reg;
        suc_wdata = ord_rdata;
        unique case (state_reg)
            S_FILL:
            begin
                ord_we = 1'b1;
            end
            S_Q_READ:
            begin
                ord_raddr = qidx_reg[AW-1:0];
            end
            S_RD_J:
            begin
                ord_raddr = j_reg;
            end
            S_SWAP:
            begin
                // first write order[i] <= order[j], then order[j] <= old order[i]
                ord_we    = 1'b1;
                ord_waddr = swap_hi_reg ? j_reg : i_reg;
                ord_wdata = swap_hi_reg ? vi_reg : ord_rdata;
            end
            S_L_RD:
            begin
                // order[i-1] arrives; link order[i-2] to it once there is a previous line
                ord_raddr = i_reg;
                suc_we    = (i_reg != AW'(1));
            end
            S_L_WR:
            begin
                suc_we    = 1'b1;
                suc_wdata = first_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            line_count_reg <= LineCountReset;
            seed_reg       <= SeedReset;
            ready_reg      <= 1'b0;
            done           <= 1'b0;
            swap_hi_reg    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_LINE_COUNT: line_count_reg <= cfg_data[LcW-1:0];
                    REG_SEED:       seed_reg       <= cfg_data;
                    default:        ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        qidx_reg <= index;
                        n_reg    <= n_eff;
                        if (action_t'(action) == ACT_GENERATE)
                        begin
                            gen_reg   <= seed_reg;
                            i_reg     <= '0;
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            oor_reg   <= ({1'b0, index} >= n_eff);
                            state_reg <= S_Q_READ;
                        end
                    end
                end
                S_Q_READ:
                begin
                    state_reg <= S_Q_OUT;
                end
                S_Q_OUT:
                begin
                    done             <= 1'b1;
                    table_valid      <= ready_reg;
                    out_of_range     <= oor_reg;
                    line_at_position <= (oor_reg || !ready_reg) ? '0 : IdxW'(ord_rdata);
                    successor_line   <= (oor_reg || !ready_reg) ? '0 : IdxW'(suc_rdata);
                    state_reg        <= S_IDLE;
                end
                S_FILL:
                begin
                    // identity fill, then start the shuffle from the top
                    if (NW'(i_reg) + NW'(1) == n_reg)
                    begin
                        if (i_reg == '0)
                        begin
                            state_reg <= S_L_RD0;
                        end
                        else
                        begin
                            state_reg <= S_RAND;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                S_RAND:
                begin
                    // advance generator; divider latches the new draw at this edge
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        j_reg     <= div_rem[AW-1:0];
                        state_reg <= S_RD_I;
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_RD_J;
                end
                S_RD_J:
                begin
                    vi_reg    <= ord_rdata;
                    state_reg <= S_SWAP;
                end
                S_SWAP:
                begin
                    swap_hi_reg <= !swap_hi_reg;
                    if (swap_hi_reg)
                    begin
                        if (i_reg == AW'(1))
                        begin
                            i_reg     <= '0;
                            state_reg <= S_L_RD0;
                        end
                        else
                        begin
                            i_reg     <= i_reg - AW'(1);
                            state_reg <= S_RAND;
                        end
                    end
                end
                S_L_RD0:
                begin
                    // order[0] read is issued (raddr = i = 0)
                    state_reg <= S_L_RD;
                    i_reg     <= AW'(1);
                end
                S_L_RD:
                begin
                    // i runs 1..n; n equal to capacity shows up as i wrapped to zero
                    cur_reg <= ord_rdata;
                    if (i_reg == AW'(1))
                    begin
                        first_reg <= ord_rdata;
                    end
                    if (i_reg == n_reg[AW-1:0])
                    begin
                        state_reg <= S_L_WR;
                    end
                    else
                    begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                S_L_WR:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    ready_reg        <= 1'b1;
                    done             <= 1'b1;
                    table_valid      <= 1'b1;
                    out_of_range     <= 1'b0;
                    line_at_position <= '0;
                    successor_line   <= '0;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_RAND)
            begin
                gen_reg <= rand_next;
            end
        end
    end
endmodule

[design/rcpg_divider.sv]
// Restoring remainder unit: 64-bit dividend modulo a narrow divisor.
// One quotient bit per cycle; imports rcpg_pkg.
module rcpg_divider
    import rcpg_pkg::*;
#(
    parameter int unsigned DW = 13
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [63:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] remainder
);
    logic [63:0]   quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] div_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    assign shifted   = {rem_reg[DW-1:0], quo_reg[63]};
    assign diff      = shifted - {1'b0, div_reg};
    assign remainder = rem_reg[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // one restoring step: shift in next bit, subtract if it fits
                quo_reg <= {quo_reg[62:0], 1'b0};
                rem_reg <= diff[DW] ? shifted : diff;
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

[design/rcpg_tables.sv]
// Order and successor memories, one write and one registered read port each.
// Uses rcpg_pkg for nothing beyond the import convention.
module rcpg_tables
    import rcpg_pkg::*;
#(
    parameter int unsigned AW = 12
)
(
    input  logic          clk,
    input  logic          ord_we,
    input  logic [AW-1:0] ord_waddr,
    input  logic [AW-1:0] ord_wdata,
    input  logic [AW-1:0] ord_raddr,
    output logic [AW-1:0] ord_rdata,
    input  logic          suc_we,
    input  logic [AW-1:0] suc_waddr,
    input  logic [AW-1:0] suc_wdata,
    input  logic [AW-1:0] suc_raddr,
    output logic [AW-1:0] suc_rdata
);
    logic [AW-1:0] ord_mem [2**AW];
    logic [AW-1:0] suc_mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (suc_we)
        begin
            suc_mem[suc_waddr] <= suc_wdata;
        end
        suc_rdata <= suc_mem[suc_raddr];
    end
endmodule

[design/rcpg_checker.sv]
// Port-level checker for random_cyclic_permutation_gen_unit, with its bind.
// Depends on the unit's ports only.
module rcpg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [11:0] line_at_position,
    input logic [11:0] successor_line,
    input logic        table_valid,
    input logic        out_of_range
);
    // an accepted beat always makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // a result beat ends the item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // flagged or invalid results carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_of_range || !table_valid)) |->
            (line_at_position == 12'd0 && successor_line == 12'd0))
        else $error("nonzero payload on flagged beat");

    // a valid result beat is never directly followed by an invalid one
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_valid) |=> !(done && !table_valid))
        else $error("table_valid dropped");
endmodule

bind random_cyclic_permutation_gen_unit rcpg_checker u_rcpg_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .line_at_position(line_at_position), .successor_line(successor_line),
    .table_valid(table_valid), .out_of_range(out_of_range)
);

[verif/random_cyclic_permutation_gen_unit_test.sv]
// Testbench for random_cyclic_permutation_gen_unit: shuffle generation and table queries.
// Depends on rcpg_pkg and the unit RTL; self-checking against an in-bench predictor.
module random_cyclic_permutation_gen_unit_test;
    import rcpg_pkg::*;

    localparam int unsigned Lines = 4096;
    localparam int unsigned CycleLimit = 12000000;

    // one pending beat for the driver: either a register write or a command
    typedef struct {
        bit           is_write;
        reg_index_t   reg_idx;
        logic [63:0]  wdata;
        action_t      act;
        logic [11:0]  idx;
    } beat_t;

    typedef struct {
        logic [11:0] line;
        logic [11:0] succ;
        logic        valid;
        logic        oor;
    } answer_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [IdxW-1:0]     index;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_index;
    logic [CfgW-1:0]     cfg_data;
    logic                done;
    logic [IdxW-1:0]     line_at_position;
    logic [IdxW-1:0]     successor_line;
    logic                table_valid;
    logic                out_of_range;

    beat_t   pending_beats[$];
    answer_t awaited_answers[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      gap_left = 0;
    int      generates_sent = 0;
    int      queries_sent = 0;

    // predictor copy of the block's state
    logic [11:0] perm_order[Lines];
    logic [11:0] perm_succ[Lines];
    logic        perm_ready;
    logic [12:0] lines_reg;
    logic [63:0] seed_reg;

    random_cyclic_permutation_gen_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .index            (index),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .line_at_position (line_at_position),
        .successor_line   (successor_line),
        .table_valid      (table_valid),
        .out_of_range     (out_of_range)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // clamp the raw line count into 1..Lines
    function automatic int unsigned active_lines(input logic [12:0] raw);
        if (raw == 0)
            return 1;
        if (raw > Lines)
            return Lines;
        return raw;
    endfunction

    // shuffle the identity with xorshift64 draws, then link the order into one cycle
    task automatic build_permutation();
        int unsigned n;
        logic [63:0] x;
        logic [63:0] j;
        logic [11:0] t;
        n = active_lines(lines_reg);
        x = seed_reg;
        for (int unsigned i = 0; i < n; i++)
            perm_order[i] = i[11:0];
        for (int unsigned i = n - 1; i > 0; i--)
        begin
            x = x ^ (x << 13);
            x = x ^ (x >> 7);
            x = x ^ (x << 17);
            j = x % 64'(i + 1);
            t = perm_order[i];
            perm_order[i] = perm_order[j];
            perm_order[j] = t;
        end
        for (int unsigned i = 0; i < n; i++)
            perm_succ[perm_order[i]] = perm_order[(i + 1 == n) ? 0 : i + 1];
        perm_ready = 1'b1;
    endtask

    task automatic predict_answer(input beat_t b);
        answer_t a;
        a = '{line: '0, succ: '0, valid: 1'b0, oor: 1'b0};
        if (b.act == ACT_GENERATE)
            build_permutation();
        else if (b.idx >= active_lines(lines_reg))
            a.oor = 1'b1;
        else if (perm_ready)
        begin
            a.line = perm_order[b.idx];
            a.succ = perm_succ[b.idx];
        end
        a.valid = perm_ready;
        awaited_answers.push_back(a);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h, expected %0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Driver: hold start until the beat is taken, apply register writes only when idle.
    always @(posedge clk or negedge rst_n)
    begin
        logic  next_start;
        logic  next_we;
        beat_t b;
        if (!rst_n)
        begin
            start     <= 1'b0;
            action    <= 1'b0;
            index     <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            perm_ready = 1'b0;
            lines_reg  = LineCountReset;
            seed_reg   = SeedReset;
        end
        else
        begin
            next_start = start;
            next_we    = 1'b0;
            if (start && !busy)
            begin
                predict_answer('{is_write: 1'b0, reg_idx: REG_LINE_COUNT, wdata: '0,
                                 act: action_t'(action), idx: index});
                next_start = 1'b0;
            end
            if (!next_start && pending_beats.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_beats[0].is_write)
                begin
                    // wait for the block to drain before touching a register
                    if (!start && !busy && awaited_answers.size() == 0)
                    begin
                        b = pending_beats.pop_front();
                        next_we = 1'b1;
                        cfg_index <= b.reg_idx;
                        cfg_data  <= b.wdata;
                        if (b.reg_idx == REG_LINE_COUNT)
                            lines_reg = b.wdata[12:0];
                        else
                            seed_reg = b.wdata;
                    end
                end
                else
                begin
                    b = pending_beats.pop_front();
                    action <= b.act;
                    index  <= b.idx;
                    next_start = 1'b1;
                    gap_left = pick_gap();
                end
            end
            start  <= next_start;
            cfg_we <= next_we;
        end
    end

    // Monitor: every done beat must match the oldest awaited answer.
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && done)
        begin
            if (awaited_answers.size() == 0)
                report_mismatch("unexpected result beat", 64'd1, 64'd0);
            else
            begin
                a = awaited_answers.pop_front();
                if (line_at_position !== a.line)
                    report_mismatch("line_at_position", line_at_position, a.line);
                if (successor_line !== a.succ)
                    report_mismatch("successor_line", successor_line, a.succ);
                if (table_valid !== a.valid)
                    report_mismatch("table_valid", table_valid, a.valid);
                if (out_of_range !== a.oor)
                    report_mismatch("out_of_range", out_of_range, a.oor);
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus builder. Track the largest generated line count so no query
    // ever lands on a table entry that no generate has written.
    int unsigned stim_lines;
    int unsigned max_built;
    logic        stim_ready;

    task automatic add_write(input reg_index_t r, input logic [63:0] d);
        pending_beats.push_back('{is_write: 1'b1, reg_idx: r, wdata: d,
                                  act: ACT_GENERATE, idx: '0});
        if (r == REG_LINE_COUNT)
            stim_lines = active_lines(d[12:0]);
    endtask

    task automatic add_command(input action_t a, input logic [11:0] i);
        pending_beats.push_back('{is_write: 1'b0, reg_idx: REG_LINE_COUNT, wdata: '0,
                                  act: a, idx: i});
        if (a == ACT_GENERATE)
        begin
            stim_ready = 1'b1;
            if (stim_lines > max_built)
                max_built = stim_lines;
            generates_sent++;
        end
        else
            queries_sent++;
    endtask

    // in-range query limited to written entries, or any index before tables exist
    task automatic add_safe_query();
        int unsigned top;
        top = stim_ready ? ((stim_lines < max_built) ? stim_lines : max_built) : stim_lines;
        add_command(ACT_QUERY, 12'($urandom_range(0, top - 1)));
    endtask

    task automatic add_oor_query();
        if (stim_lines < Lines)
            add_command(ACT_QUERY, 12'($urandom_range(stim_lines, Lines - 1)));
        else
            add_safe_query();
    endtask

    initial
    begin
        int unsigned n;
        int          r;
        logic [63:0] s;
        stim_lines = LineCountReset;
        max_built  = 0;
        stim_ready = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // queries before any table exists answer zeros with table_valid low
        add_command(ACT_QUERY, 12'd0);
        add_command(ACT_QUERY, 12'hfff);
        // one-line cycle with a zero seed; index past the end is flagged
        add_write(REG_LINE_COUNT, 64'd1);
        add_write(REG_SEED, 64'd0);
        add_command(ACT_GENERATE, 12'habc);
        add_command(ACT_QUERY, 12'd0);
        add_command(ACT_QUERY, 12'hfff);
        // line count zero behaves as one
        add_write(REG_LINE_COUNT, 64'd0);
        add_write(REG_SEED, 64'hffff_ffff_ffff_ffff);
        add_command(ACT_GENERATE, 12'd0);
        add_command(ACT_QUERY, 12'd0);
        add_command(ACT_QUERY, 12'd1);
        // zero seed keeps every swap index at zero
        add_write(REG_LINE_COUNT, 64'd5);
        add_write(REG_SEED, 64'd0);
        add_command(ACT_GENERATE, 12'd0);
        for (int i = 0; i < 6; i++)
            add_command(ACT_QUERY, 12'(i));
        // full-size table with the reset seed value; the one expensive generate
        add_write(REG_LINE_COUNT, 64'd4096);
        add_write(REG_SEED, SeedReset);
        add_command(ACT_GENERATE, 12'd0);
        add_command(ACT_QUERY, 12'd0);
        add_command(ACT_QUERY, 12'hfff);
        for (int i = 0; i < 20; i++)
            add_safe_query();
        // a count above the maximum clamps to the maximum
        add_write(REG_LINE_COUNT, 64'h1fff);
        add_command(ACT_QUERY, 12'hfff);
        add_command(ACT_QUERY, 12'h555);

        // random phases: fresh settings, a generate, then mixed queries
        while (queries_sent + generates_sent < 1250)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                n = $urandom_range(1, 32);
            else
                n = $urandom_range(33, 300);
            r = $urandom_range(0, 19);
            if (r == 0)
                s = 64'd0;
            else if (r == 1)
                s = 64'hffff_ffff_ffff_ffff;
            else
                s = {$urandom, $urandom};
            add_write(REG_LINE_COUNT, {51'd0, 13'(n)});
            add_write(REG_SEED, s);
            add_command(ACT_GENERATE, 12'($urandom));
            repeat ($urandom_range(15, 40))
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    add_command(ACT_GENERATE, 12'($urandom));
                else if (r < 25)
                    add_oor_query();
                else
                    add_safe_query();
            end
        end

        while (pending_beats.size() > 0 || start || awaited_answers.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Covered %0d generates and %0d queries over line counts from 1 to 4096,",
                 generates_sent, queries_sent);
        $display("including zero and all-ones seeds and clamped line counts.");
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
